// ----- design/lvbs_pkg.sv -----
package lvbs_pkg;

  // Store geometry
  localparam int unsigned CHUNK_DEPTH = 1024;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned ADDR_W      = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(CHUNK_DEPTH + 1);
  localparam int unsigned OBITS_W     = 7;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_POP   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_UNDER = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [30:0] field_value;
    logic [4:0]  field_bits;
  } in_item_t;

  typedef struct packed {
    logic [30:0] popped_value;
    logic [1:0]  status;
  } out_item_t;

  // Classified command as held in the queue: value already cut to its width
  typedef struct packed {
    logic [1:0]  command;
    logic [30:0] value;
    logic [4:0]  nbits;
  } op_t;

  // Low n bits set, all bits for n of a full word or more
  function automatic logic [WORD_BITS-1:0] low_mask(input logic [OBITS_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    if (n >= OBITS_W'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (WORD_BITS'(1) << n) - WORD_BITS'(1);
    end
    return m;
  endfunction

endpackage

// ----- design/lifo_variable_bit_stack.sv -----
// Result path: an accepted command is written to the command queue, executed at its head, then its result
// is registered and strobed; a pop that reloads a stored word adds one chunk store read before the result.
// Throughput: one command per cycle, except that a reloading pop holds the queue head
// until the registered read port of the chunk store returns the stored word.
// Reset: synchronous active-low rst_n empties the stack and the command queue;
// chunk store contents are kept. Results are strobed once; the receiver cannot stall.
module lifo_variable_bit_stack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lvbs_pkg::in_item_t  in_item,
  output logic                out_valid,
  output lvbs_pkg::out_item_t out_item
);

  logic                              head_valid;
  lvbs_pkg::op_t                     head;
  logic                              head_take;
  logic                              ram_we;
  logic [lvbs_pkg::ADDR_W-1:0]       ram_waddr;
  logic [lvbs_pkg::WORD_BITS-1:0]    ram_wdata;
  logic                              ram_re;
  logic [lvbs_pkg::ADDR_W-1:0]       ram_raddr;
  logic [lvbs_pkg::WORD_BITS-1:0]    ram_rdata;

  lvbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head       (head),
    .head_take  (head_take)
  );

  lvbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_take  (head_take),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

  lvbs_ram #(
    .WIDTH (lvbs_pkg::WORD_BITS),
    .DEPTH (lvbs_pkg::CHUNK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- design/lvbs_ram.sv -----
module lvbs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/lvbs_front.sv -----
module lvbs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lvbs_pkg::in_item_t in_item,
  output logic               head_valid,
  output lvbs_pkg::op_t      head,
  input  logic               head_take
);

  lvbs_pkg::op_t                    q_r [lvbs_pkg::QUEUE_DEPTH];
  logic [lvbs_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [lvbs_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [lvbs_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             accept;
  lvbs_pkg::op_t                    op;

  // Classify: keep the command, cut the value to its field width
  always_comb begin
    op.command = in_item.command;
    op.nbits   = in_item.field_bits;
    op.value   = in_item.field_value & ((31'd1 << in_item.field_bits) - 31'd1);
  end

  assign busy       = (count_r == lvbs_pkg::QCNT_W'(lvbs_pkg::QUEUE_DEPTH));
  assign accept     = start && !busy;
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (accept) begin
      wr_ptr_nxt = (wr_ptr_r == lvbs_pkg::QPTR_W'(lvbs_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (head_take) begin
      rd_ptr_nxt = (rd_ptr_r == lvbs_pkg::QPTR_W'(lvbs_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (accept && !head_take) begin
      count_nxt = count_r + 1'b1;
    end else if (!accept && head_take) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= op;
    end
  end

endmodule

// ----- design/lvbs_back.sv -----
module lvbs_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              head_valid,
  input  lvbs_pkg::op_t                     head,
  output logic                              head_take,
  output logic                              ram_we,
  output logic [lvbs_pkg::ADDR_W-1:0]       ram_waddr,
  output logic [lvbs_pkg::WORD_BITS-1:0]    ram_wdata,
  output logic                              ram_re,
  output logic [lvbs_pkg::ADDR_W-1:0]       ram_raddr,
  input  logic [lvbs_pkg::WORD_BITS-1:0]    ram_rdata,
  output logic                              out_valid,
  output lvbs_pkg::out_item_t               out_item
);

  localparam logic S_EXEC = 1'b0;
  localparam logic S_LOAD = 1'b1;

  localparam logic [lvbs_pkg::OBITS_W-1:0] FULL_W = lvbs_pkg::OBITS_W'(lvbs_pkg::WORD_BITS);

  logic                              state_r, state_nxt;
  logic [lvbs_pkg::CNT_W-1:0]        stored_r, stored_nxt;
  logic [lvbs_pkg::WORD_BITS-1:0]    word_r, word_nxt;
  logic [lvbs_pkg::OBITS_W-1:0]      obits_r, obits_nxt;
  logic                              out_valid_r;
  lvbs_pkg::out_item_t               out_item_r;

  logic                              done;
  logic [lvbs_pkg::WORD_BITS-1:0]    res;
  logic [1:0]                        stat;
  logic [lvbs_pkg::OBITS_W-1:0]      nb;
  logic [lvbs_pkg::OBITS_W-1:0]      total;
  logic [lvbs_pkg::OBITS_W-1:0]      left;
  logic [lvbs_pkg::OBITS_W-1:0]      right_sh;
  logic [lvbs_pkg::OBITS_W-1:0]      need;
  logic [lvbs_pkg::WORD_BITS-1:0]    val64;
  logic [lvbs_pkg::WORD_BITS-1:0]    top_bits;
  logic [lvbs_pkg::WORD_BITS-1:0]    word_fill;
  logic                              store_full;

  // Shared operands
  always_comb begin
    nb         = {2'b00, head.nbits};
    total      = obits_r + nb;
    left       = total - FULL_W;
    right_sh   = nb - left;
    need       = nb - obits_r;
    val64      = {33'd0, head.value};
    top_bits   = (obits_r == '0) ? '0 : (word_r >> (FULL_W - obits_r));
    word_fill  = (word_r << nb) | val64;
    store_full = (stored_r >= lvbs_pkg::CNT_W'(lvbs_pkg::CHUNK_DEPTH));
    ram_waddr  = lvbs_pkg::ADDR_W'(stored_r);
    ram_raddr  = lvbs_pkg::ADDR_W'(stored_r - 1'b1);
  end

  // Execute the command at the queue head
  always_comb begin
    state_nxt  = state_r;
    stored_nxt = stored_r;
    word_nxt   = word_r;
    obits_nxt  = obits_r;
    done       = 1'b0;
    res        = '0;
    stat       = lvbs_pkg::STAT_OK;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_wdata  = word_fill;
    unique case (state_r)
      S_EXEC: begin
        if (head_valid) begin
          unique case (head.command)
            lvbs_pkg::CMD_PUSH: begin
              done = 1'b1;
              if (total >= FULL_W && store_full) begin
                stat = lvbs_pkg::STAT_FULL;
              end else if (total <= FULL_W) begin
                if (total == FULL_W) begin
                  ram_we     = 1'b1;
                  stored_nxt = stored_r + 1'b1;
                  word_nxt   = '0;
                  obits_nxt  = '0;
                end else begin
                  word_nxt  = word_fill;
                  obits_nxt = total;
                end
              end else begin
                // field splits: high part closes the word, low part opens the next
                ram_we     = 1'b1;
                ram_wdata  = (word_r << right_sh) | (val64 >> left);
                stored_nxt = stored_r + 1'b1;
                word_nxt   = val64 & lvbs_pkg::low_mask(left);
                obits_nxt  = left;
              end
            end
            lvbs_pkg::CMD_FLUSH: begin
              done = 1'b1;
              if (obits_r == '0) begin
                word_nxt = '0;
              end else if (obits_r < FULL_W) begin
                word_nxt = word_r << (FULL_W - obits_r);
              end
            end
            lvbs_pkg::CMD_POP: begin
              if (obits_r > nb) begin
                done      = 1'b1;
                res       = top_bits & lvbs_pkg::low_mask(nb);
                obits_nxt = obits_r - nb;
              end else if (stored_r == '0) begin
                done      = 1'b1;
                obits_nxt = '0;
                if (obits_r == nb) begin
                  res = top_bits & lvbs_pkg::low_mask(nb);
                end else begin
                  res  = top_bits;
                  stat = lvbs_pkg::STAT_UNDER;
                end
              end else begin
                // fetch the previous word, finish next cycle
                ram_re    = 1'b1;
                state_nxt = S_LOAD;
              end
            end
            lvbs_pkg::CMD_CLEAR: begin
              done       = 1'b1;
              stored_nxt = '0;
              word_nxt   = '0;
              obits_nxt  = '0;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_LOAD: begin
        done       = 1'b1;
        state_nxt  = S_EXEC;
        stored_nxt = stored_r - 1'b1;
        word_nxt   = ram_rdata;
        if (obits_r == nb) begin
          res       = top_bits & lvbs_pkg::low_mask(nb);
          obits_nxt = FULL_W;
        end else begin
          // join the split field: high bits come from the reloaded word
          res       = top_bits | ((ram_rdata & lvbs_pkg::low_mask(need)) << obits_r);
          obits_nxt = FULL_W - need;
        end
      end
      default: begin
        state_nxt = S_EXEC;
      end
    endcase
  end

  assign head_take = done;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EXEC;
      stored_r    <= '0;
      word_r      <= '0;
      obits_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stored_r    <= stored_nxt;
      word_r      <= word_nxt;
      obits_r     <= obits_nxt;
      out_valid_r <= done;
    end
  end

  // Register the result of each finished command
  always_ff @(posedge clk) begin
    if (done) begin
      out_item_r.popped_value <= res[30:0];
      out_item_r.status       <= stat;
    end
  end

endmodule
